@@ rtl/core/dsp_pkg.sv @@
// Package for the datagram sequence placer: codes, sizes and the result record.
`timescale 1ns / 1ps

package dsp_pkg;

  localparam int unsigned MAX_COUNT  = 256;
  localparam int unsigned SLOT_COUNT = 32;

  // Register reset values
  localparam logic [6:0]  WPD_RESET        = 7'd32;
  localparam logic [14:0] WCAP_RESET       = 15'd16384;
  localparam logic [3:0]  STRAY_RESET      = 4'd8;
  localparam logic [8:0]  STREAM_MIN_RESET = 9'd32;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_DATAGRAM = 2'd1,
    OP_TIMEOUT  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_WINDOW_PER_DGRAM = 2'd0,
    REG_WINDOW_CAP       = 2'd1,
    REG_STRAY_LIMIT      = 2'd2,
    REG_STREAM_MIN       = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_STRAY    = 3'd0,
    KIND_PLACED   = 3'd1,
    KIND_HELD     = 3'd2,
    KIND_COMPLETE = 3'd3,
    KIND_REFUSED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RESTART_NONE   = 2'd0,
    RESTART_WINDOW = 2'd1,
    RESTART_STALE  = 2'd2
  } restart_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] slot;
    logic [7:0] index;
    logic       carry;
    logic [7:0] hstart;
    logic [8:0] hcount;
    restart_e   rkind;
    logic [8:0] recv;
    logic       tmo;
    logic       tail;
    logic       last;
  } result_t;

endpackage

@@ rtl/core/datagram_sequence_placer.sv @@
// Datagram sequence placer: places datagrams by wrapping sequence number into transfers.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   input   | in        | in_valid_i / in_stall_o    | opcode_i slot_i count_i seq_i
//   result  | out       | out_valid_o / out_stall_i  | kind_o .. last_o, one result a beat
//   config  | in        | cfg_we_i                   | cfg_index_i cfg_data_i
//
// An item is decided in the cycle it is accepted and its results enter a four-entry
// result queue at that edge; one item per cycle is taken as long as the queue holds two
// or fewer results. An item with two results needs two output beats, so the output port
// sets the sustained rate for those. Reset clears all control state at once; there is
// no clearing pass. Output stalls back up through the queue into in_stall_o.
`timescale 1ns / 1ps

module datagram_sequence_placer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  slot_i,
  input  logic [8:0]  count_i,
  input  logic [15:0] seq_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [4:0]  slot_out_o,
  output logic [7:0]  index_o,
  output logic        from_carry_o,
  output logic [7:0]  hole_start_o,
  output logic [8:0]  hole_count_o,
  output logic [1:0]  restart_kind_o,
  output logic [8:0]  received_count_o,
  output logic        timed_out_o,
  output logic        tail_lost_o,
  output logic        last_o
);

  // configuration registers
  logic [6:0]  wpd_q;
  logic [14:0] wcap_q;
  logic [3:0]  stray_limit_q;
  logic [8:0]  stream_min_q;

  // transfer state
  logic        active_q, active_d;
  logic [4:0]  cur_slot_q, cur_slot_d;
  logic [8:0]  cur_count_q, cur_count_d;
  logic [8:0]  placed_q, placed_d;
  logic [8:0]  wpos_q, wpos_d;
  logic        base_valid_q, base_valid_d;
  logic [15:0] base_seq_q, base_seq_d;
  logic        expect_valid_q, expect_valid_d;
  logic [15:0] expect_seq_q, expect_seq_d;
  logic [3:0]  stale_run_q, stale_run_d;
  logic [15:0] stale_seq_q, stale_seq_d;
  logic [8:0]  stale_pos_q, stale_pos_d;
  logic        held_valid_q, held_valid_d;
  logic [15:0] held_seq_q, held_seq_d;

  // result queue
  dsp_pkg::result_t                    fifo_q [dsp_pkg::FIFO_DEPTH];
  logic [dsp_pkg::FIFO_AW-1:0]         rd_ptr_q, wr_ptr_q;
  logic [dsp_pkg::FIFO_AW:0]           fill_q;
  logic                                pop;
  logic [1:0]                          n_push;
  dsp_pkg::result_t                    res0, res1;

  logic in_fire;
  logic is_begin, is_dgram, is_timeout, op_ok;

  // datagram context
  logic [8:0]  sat_count, ctx_count, ctx_wpos, ctx_placed;
  logic [4:0]  ctx_slot;
  logic        ctx_bvalid;
  logic [15:0] ctx_base, dg_seq, base0;
  logic        run_dg;

  logic [15:0]        win_prod;
  logic [14:0]        window;
  logic [15:0]        diff0;
  logic signed [16:0] d0x, winx;
  logic               restart, stray_path, stray_drop, stale_restart;
  logic [3:0]         run_inc;
  logic [15:0]        first_seq, base_st, diff_st, base_re;
  logic [8:0]         first_pos;
  logic [15:0]        base1, d1;
  dsp_pkg::restart_e  rkind;
  logic [16:0]        idx;
  logic               held, placed;
  logic [8:0]         new_wpos, wpos_post, placed_post;
  logic               cmp_after, cmp_now;

  // completion unit inputs
  logic        cmp_timed, cmp_bvalid, stream;
  logic [8:0]  cmp_count, cmp_wpos, cmp_placed;
  logic [15:0] cmp_base;
  dsp_pkg::result_t res_acc, res_cmp, res_ref;

  assign in_stall_o = fill_q > (dsp_pkg::FIFO_AW + 1)'(dsp_pkg::FIFO_DEPTH - 2);
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---- decode ----
  always_comb begin
    is_begin   = 1'b0;
    is_dgram   = 1'b0;
    is_timeout = 1'b0;
    unique case (opcode_i)
      dsp_pkg::OP_BEGIN:    is_begin   = 1'b1;
      dsp_pkg::OP_DATAGRAM: is_dgram   = 1'b1;
      dsp_pkg::OP_TIMEOUT:  is_timeout = 1'b1;
      default: ;
    endcase
  end

  assign op_ok = (is_begin && !active_q && (count_i != 9'd0) &&
                  ({1'b0, slot_i} < 6'(dsp_pkg::SLOT_COUNT))) ||
                 ((is_dgram || is_timeout) && active_q);

  assign sat_count = (count_i > 9'(dsp_pkg::MAX_COUNT)) ? 9'(dsp_pkg::MAX_COUNT) : count_i;

  // A begin works on a fresh transfer and replays the held datagram, if any.
  assign ctx_count  = is_begin ? sat_count    : cur_count_q;
  assign ctx_slot   = is_begin ? slot_i       : cur_slot_q;
  assign ctx_wpos   = is_begin ? 9'd0         : wpos_q;
  assign ctx_placed = is_begin ? 9'd0         : placed_q;
  assign ctx_bvalid = is_begin ? 1'b0         : base_valid_q;
  assign ctx_base   = is_begin ? 16'd0        : base_seq_q;
  assign dg_seq     = is_begin ? held_seq_q   : seq_i;
  assign run_dg     = is_begin ? held_valid_q : is_dgram;

  // ---- placement ----
  assign base0    = ctx_bvalid ? ctx_base : (expect_valid_q ? expect_seq_q : dg_seq);
  assign win_prod = 16'(wpd_q) * 16'(ctx_count);
  assign window   = (win_prod > {1'b0, wcap_q}) ? wcap_q : win_prod[14:0];
  assign diff0    = dg_seq - (base0 + 16'(ctx_wpos));
  assign d0x      = $signed({diff0[15], diff0});
  assign winx     = $signed({2'b00, window});
  assign restart  = (d0x >= winx) || (d0x <= -winx);

  assign stray_path    = diff0[15] && !restart;
  assign run_inc       = (stale_run_q == 4'hF) ? 4'hF : stale_run_q + 4'd1;
  assign stray_drop    = stray_path && (run_inc < stray_limit_q);
  assign stale_restart = stray_path && !stray_drop;

  // stale-run anchor: the first stale datagram marks where the new base lies
  assign first_seq = (stale_run_q == 4'd0) ? dg_seq   : stale_seq_q;
  assign first_pos = (stale_run_q == 4'd0) ? ctx_wpos : stale_pos_q;
  assign base_st   = first_seq - 16'(first_pos);
  assign diff_st   = dg_seq - (base_st + 16'(ctx_wpos));
  assign base_re   = dg_seq - 16'(ctx_wpos);

  always_comb begin
    base1 = base0;
    d1    = diff0;
    rkind = dsp_pkg::RESTART_NONE;
    if (restart) begin
      base1 = base_re;
      d1    = 16'd0;
      rkind = dsp_pkg::RESTART_WINDOW;
    end else if (stale_restart) begin
      rkind = dsp_pkg::RESTART_STALE;
      if (diff_st[15]) begin
        // anchor would fall behind the write position: anchor on this datagram
        base1 = base_re;
        d1    = 16'd0;
      end else begin
        base1 = base_st;
        d1    = diff_st;
      end
    end
  end

  assign idx       = 17'(ctx_wpos) + 17'(d1);
  assign held      = !stray_drop && (idx >= 17'(ctx_count));
  assign placed    = !stray_drop && !held;
  assign new_wpos  = 9'(idx) + 9'd1;
  assign wpos_post = (run_dg && placed) ? new_wpos : ctx_wpos;
  assign placed_post = ctx_placed + ((run_dg && placed) ? 9'd1 : 9'd0);
  assign cmp_after = run_dg && (held || (placed && (new_wpos >= ctx_count)));
  assign cmp_now   = op_ok && (is_timeout || cmp_after);

  always_comb begin
    res_acc        = '0;
    res_acc.slot   = ctx_slot;
    res_acc.carry  = is_begin;
    res_acc.rkind  = stray_drop ? dsp_pkg::RESTART_NONE : rkind;
    res_acc.last   = !cmp_after;
    if (stray_drop) begin
      res_acc.kind = dsp_pkg::KIND_STRAY;
    end else if (held) begin
      res_acc.kind = dsp_pkg::KIND_HELD;
    end else begin
      res_acc.kind   = dsp_pkg::KIND_PLACED;
      res_acc.index  = idx[7:0];
      res_acc.hstart = ctx_wpos[7:0];
      res_acc.hcount = d1[8:0];
    end
  end

  // ---- completion ----
  assign cmp_timed  = is_timeout;
  assign cmp_count  = is_timeout ? cur_count_q  : ctx_count;
  assign cmp_wpos   = is_timeout ? wpos_q       : wpos_post;
  assign cmp_placed = is_timeout ? placed_q     : placed_post;
  assign cmp_bvalid = is_timeout ? base_valid_q : 1'b1;
  assign cmp_base   = is_timeout ? base_seq_q   : base1;
  assign stream     = cmp_count >= stream_min_q;

  always_comb begin
    res_cmp      = '0;
    res_cmp.kind = dsp_pkg::KIND_COMPLETE;
    res_cmp.slot = ctx_slot;
    res_cmp.last = 1'b1;
    if (cmp_wpos < cmp_count) begin
      res_cmp.hstart = cmp_wpos[7:0];
      res_cmp.hcount = cmp_count - cmp_wpos;
      res_cmp.tail   = stream;
    end
    res_cmp.recv = cmp_placed;
    res_cmp.tmo  = cmp_timed;
    if (stream && (cmp_placed != 9'd0)) begin
      res_cmp.recv = cmp_count;
      res_cmp.tmo  = 1'b0;
    end else if (stream && !cmp_timed) begin
      res_cmp.recv = cmp_count;
    end
  end

  always_comb begin
    res_ref      = '0;
    res_ref.kind = dsp_pkg::KIND_REFUSED;
    res_ref.slot = cur_slot_q;
    res_ref.last = 1'b1;
  end

  // ---- result selection ----
  always_comb begin
    res0   = res_ref;
    res1   = res_cmp;
    n_push = 2'd0;
    if (in_fire) begin
      if (!op_ok) begin
        n_push = 2'd1;
      end else if (is_timeout) begin
        res0   = res_cmp;
        n_push = 2'd1;
      end else if (run_dg) begin
        res0   = res_acc;
        n_push = cmp_after ? 2'd2 : 2'd1;
      end
    end
  end

  // ---- next state ----
  always_comb begin
    active_d       = active_q;
    cur_slot_d     = cur_slot_q;
    cur_count_d    = cur_count_q;
    placed_d       = placed_q;
    wpos_d         = wpos_q;
    base_valid_d   = base_valid_q;
    base_seq_d     = base_seq_q;
    expect_valid_d = expect_valid_q;
    expect_seq_d   = expect_seq_q;
    stale_run_d    = stale_run_q;
    stale_seq_d    = stale_seq_q;
    stale_pos_d    = stale_pos_q;
    held_valid_d   = held_valid_q;
    held_seq_d     = held_seq_q;
    if (in_fire && op_ok) begin
      if (is_begin) begin
        active_d     = 1'b1;
        cur_slot_d   = slot_i;
        cur_count_d  = sat_count;
        placed_d     = 9'd0;
        wpos_d       = 9'd0;
        base_valid_d = 1'b0;
        base_seq_d   = 16'd0;
      end
      if (run_dg) begin
        base_valid_d = 1'b1;
        base_seq_d   = base1;
        placed_d     = placed_post;
        wpos_d       = wpos_post;
        if (stray_path && (stale_run_q == 4'd0)) begin
          stale_seq_d = dg_seq;
          stale_pos_d = ctx_wpos;
        end
        stale_run_d = stray_drop ? run_inc : 4'd0;
        if (is_begin && !held) begin
          held_valid_d = 1'b0;
        end
        if (is_dgram && held) begin
          held_valid_d = 1'b1;
          held_seq_d   = seq_i;
        end
      end
      if (cmp_now) begin
        active_d = 1'b0;
        if (cmp_bvalid) begin
          expect_valid_d = 1'b1;
          expect_seq_d   = cmp_base + 16'(cmp_count);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpd_q          <= dsp_pkg::WPD_RESET;
      wcap_q         <= dsp_pkg::WCAP_RESET;
      stray_limit_q  <= dsp_pkg::STRAY_RESET;
      stream_min_q   <= dsp_pkg::STREAM_MIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dsp_pkg::REG_WINDOW_PER_DGRAM: wpd_q         <= cfg_data_i[6:0];
        dsp_pkg::REG_WINDOW_CAP:       wcap_q        <= cfg_data_i;
        dsp_pkg::REG_STRAY_LIMIT:      stray_limit_q <= cfg_data_i[3:0];
        dsp_pkg::REG_STREAM_MIN:       stream_min_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      cur_slot_q     <= '0;
      cur_count_q    <= '0;
      placed_q       <= '0;
      wpos_q         <= '0;
      base_valid_q   <= 1'b0;
      base_seq_q     <= '0;
      expect_valid_q <= 1'b0;
      expect_seq_q   <= '0;
      stale_run_q    <= '0;
      stale_seq_q    <= '0;
      stale_pos_q    <= '0;
      held_valid_q   <= 1'b0;
      held_seq_q     <= '0;
    end else begin
      active_q       <= active_d;
      cur_slot_q     <= cur_slot_d;
      cur_count_q    <= cur_count_d;
      placed_q       <= placed_d;
      wpos_q         <= wpos_d;
      base_valid_q   <= base_valid_d;
      base_seq_q     <= base_seq_d;
      expect_valid_q <= expect_valid_d;
      expect_seq_q   <= expect_seq_d;
      stale_run_q    <= stale_run_d;
      stale_seq_q    <= stale_seq_d;
      stale_pos_q    <= stale_pos_d;
      held_valid_q   <= held_valid_d;
      held_seq_q     <= held_seq_d;
    end
  end

  // ---- result queue ----
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + dsp_pkg::FIFO_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + dsp_pkg::FIFO_AW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + dsp_pkg::FIFO_AW'(1);
      end
      fill_q <= fill_q + (dsp_pkg::FIFO_AW + 1)'(n_push) -
                (dsp_pkg::FIFO_AW + 1)'(pop);
    end
  end

  assign out_valid_o      = fill_q != '0;
  assign kind_o           = fifo_q[rd_ptr_q].kind;
  assign slot_out_o       = fifo_q[rd_ptr_q].slot;
  assign index_o          = fifo_q[rd_ptr_q].index;
  assign from_carry_o     = fifo_q[rd_ptr_q].carry;
  assign hole_start_o     = fifo_q[rd_ptr_q].hstart;
  assign hole_count_o     = fifo_q[rd_ptr_q].hcount;
  assign restart_kind_o   = fifo_q[rd_ptr_q].rkind;
  assign received_count_o = fifo_q[rd_ptr_q].recv;
  assign timed_out_o      = fifo_q[rd_ptr_q].tmo;
  assign tail_lost_o      = fifo_q[rd_ptr_q].tail;
  assign last_o           = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (dsp_pkg::FIFO_AW + 1)'(dsp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_pair_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (fill_q >= (dsp_pkg::FIFO_AW + 1)'(2)))
    else $error("first result of a pair shown without its second");

  a_complete_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmp_now) |=> !active_q)
    else $error("transfer still active after completion");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (wpos_q <= cur_count_q))
    else $error("write position beyond transfer length");
`endif

endmodule

@@ test/datagram_sequence_placer_tb.sv @@
// Self-checking testbench for the datagram sequence placer, with its own placement predictor.
`timescale 1ns / 1ps

module datagram_sequence_placer_tb;
  import dsp_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 400;

  // Placement predictor plus the queue of results it still waits for.
  class placement_scoreboard;
    logic [6:0]  win_per_dgram;
    logic [14:0] win_cap;
    logic [3:0]  stray_lim;
    logic [8:0]  stream_min;

    bit          active;
    logic [4:0]  cur_slot;
    logic [8:0]  cur_count;
    logic [8:0]  placed_count;
    logic [8:0]  write_pos;
    bit          base_valid;
    logic [15:0] base_seq;
    bit          expect_valid;
    logic [15:0] expect_seq;
    logic [3:0]  stale_run;
    logic [15:0] stale_first_seq;
    logic [8:0]  stale_first_pos;
    bit          held_valid;
    logic [15:0] held_seq;

    result_t     due[$];
    int          errors;

    function new();
      win_per_dgram = WPD_RESET;
      win_cap = WCAP_RESET;
      stray_lim = STRAY_RESET;
      stream_min = STREAM_MIN_RESET;
      active = 0;
      cur_slot = '0;
      cur_count = '0;
      placed_count = '0;
      write_pos = '0;
      base_valid = 0;
      base_seq = '0;
      expect_valid = 0;
      expect_seq = '0;
      stale_run = '0;
      stale_first_seq = '0;
      stale_first_pos = '0;
      held_valid = 0;
      held_seq = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [14:0] value);
      case (idx)
        REG_WINDOW_PER_DGRAM: win_per_dgram = value[6:0];
        REG_WINDOW_CAP:       win_cap = value;
        REG_STRAY_LIMIT:      stray_lim = value[3:0];
        REG_STREAM_MIN:       stream_min = value[8:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Signed distance of a sequence from the current write position.
    function int seq_gap(logic [15:0] seq);
      logic [15:0] diff;
      diff = seq - (base_seq + 16'(write_pos));
      return $signed(diff);
    endfunction

    function kind_e place_datagram(logic [15:0] seq, output result_t r);
      int  w;
      int  d;
      int  idx;
      bit  jump;
      r = '0;
      r.slot = cur_slot;
      if (!base_valid) begin
        base_seq = expect_valid ? expect_seq : seq;
        base_valid = 1;
      end
      w = int'(win_per_dgram) * int'(cur_count);
      if (w > int'(win_cap)) w = int'(win_cap);
      d = seq_gap(seq);
      jump = (d >= w) || (d <= -w);
      if (d < 0 && !jump) begin
        if (stale_run == 0) begin
          stale_first_seq = seq;
          stale_first_pos = write_pos;
        end
        if (stale_run < 15) stale_run++;
        if (stale_run < stray_lim) begin
          r.kind = KIND_STRAY;
          return KIND_STRAY;
        end
        r.rkind = RESTART_STALE;
        base_seq = stale_first_seq - 16'(stale_first_pos);
        d = seq_gap(seq);
        // anchor on the datagram itself when the run would land behind the write position
        if (d < 0) begin
          base_seq = seq - 16'(write_pos);
          d = 0;
        end
      end else if (jump) begin
        r.rkind = RESTART_WINDOW;
        base_seq = seq - 16'(write_pos);
        d = 0;
      end
      stale_run = '0;
      idx = int'(write_pos) + d;
      if (idx >= int'(cur_count)) begin
        r.kind = KIND_HELD;
        return KIND_HELD;
      end
      r.kind = KIND_PLACED;
      r.index = idx[7:0];
      r.hstart = write_pos[7:0];
      r.hcount = d[8:0];
      placed_count++;
      write_pos = 9'(idx + 1);
      return KIND_PLACED;
    endfunction

    function void close_transfer(bit tmo, output result_t r);
      bit stream;
      stream = cur_count >= stream_min;
      r = '0;
      r.kind = KIND_COMPLETE;
      r.slot = cur_slot;
      if (write_pos < cur_count) begin
        r.hstart = write_pos[7:0];
        r.hcount = cur_count - write_pos;
        r.tail = stream;
      end
      if (base_valid) begin
        expect_seq = base_seq + 16'(cur_count);
        expect_valid = 1;
      end
      r.recv = placed_count;
      r.tmo = tmo;
      // streams report the whole transfer unless nothing at all arrived before a timeout
      if (stream && placed_count > 0) begin
        r.recv = cur_count;
        r.tmo = 1'b0;
      end else if (stream && !tmo) begin
        r.recv = cur_count;
      end
      active = 0;
    endfunction

    function void note_input(logic [1:0] op, logic [4:0] slot, logic [8:0] count,
                             logic [15:0] seq);
      result_t r;
      result_t c;
      kind_e   k;
      bit      ok;
      ok = (op == OP_BEGIN && !active && count != 0 && slot < SLOT_COUNT) ||
           ((op == OP_DATAGRAM || op == OP_TIMEOUT) && active);
      if (!ok) begin
        r = '0;
        r.kind = KIND_REFUSED;
        r.slot = cur_slot;
        r.last = 1'b1;
        due.push_back(r);
        return;
      end
      if (op == OP_TIMEOUT) begin
        close_transfer(1'b1, r);
        r.last = 1'b1;
        due.push_back(r);
        return;
      end
      if (op == OP_BEGIN) begin
        active = 1;
        cur_slot = slot;
        cur_count = (count > MAX_COUNT) ? 9'(MAX_COUNT) : count;
        placed_count = '0;
        write_pos = '0;
        base_valid = 0;
        base_seq = '0;
        if (!held_valid) return;
        k = place_datagram(held_seq, r);
        r.carry = 1'b1;
        if (k != KIND_HELD) held_valid = 0;
      end else begin
        k = place_datagram(seq, r);
        if (k == KIND_HELD) begin
          held_valid = 1;
          held_seq = seq;
        end
      end
      if (k == KIND_HELD || (k == KIND_PLACED && write_pos >= cur_count)) begin
        due.push_back(r);
        close_transfer(1'b0, c);
        c.last = 1'b1;
        due.push_back(c);
      end else begin
        r.last = 1'b1;
        due.push_back(r);
      end
    endfunction

    function string describe(result_t r);
      return {$sformatf("kind %0d slot %0d idx %0d carry %0b hole %0d+%0d ",
                        r.kind, r.slot, r.index, r.carry, r.hstart, r.hcount),
              $sformatf("restart %0d recv %0d tmo %0b tail %0b last %0b",
                        r.rkind, r.recv, r.tmo, r.tail, r.last)};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected result: %s", describe(got));
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("result mismatch\n  expected %s\n  actual   %s",
                   describe(want), describe(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [14:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [4:0]  slot_i;
  logic [8:0]  count_i;
  logic [15:0] seq_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [4:0]  slot_out_o;
  logic [7:0]  index_o;
  logic        from_carry_o;
  logic [7:0]  hole_start_o;
  logic [8:0]  hole_count_o;
  logic [1:0]  restart_kind_o;
  logic [8:0]  received_count_o;
  logic        timed_out_o;
  logic        tail_lost_o;
  logic        last_o;

  placement_scoreboard sb;
  int          cycles;
  int          burst_left;
  int          hold_req_count;
  logic [15:0] gen_next;

  datagram_sequence_placer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .slot_i          (slot_i),
    .count_i         (count_i),
    .seq_i           (seq_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .slot_out_o      (slot_out_o),
    .index_o         (index_o),
    .from_carry_o    (from_carry_o),
    .hole_start_o    (hole_start_o),
    .hole_count_o    (hole_count_o),
    .restart_kind_o  (restart_kind_o),
    .received_count_o(received_count_o),
    .timed_out_o     (timed_out_o),
    .tail_lost_o     (tail_lost_o),
    .last_o          (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("datagram_sequence_placer_tb: FAIL");
      $finish;
    end
  end

  // Offer one beat; idle between bursts of random length.
  task automatic offer(logic [1:0] op, logic [4:0] slot, logic [8:0] count,
                       logic [15:0] seq);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    slot_i <= slot;
    count_i <= count;
    seq_i <= seq;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, slot, count, seq);
  endtask

  // Let every expected result out, then allow for items that produce none.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [14:0] wpd, logic [14:0] cap, logic [14:0] stray,
                              logic [14:0] smin);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_WINDOW_PER_DGRAM;
    cfg_data_i <= wpd;
    @(posedge clk_i);
    cfg_index_i <= REG_WINDOW_CAP;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_index_i <= REG_STRAY_LIMIT;
    cfg_data_i <= stray;
    @(posedge clk_i);
    cfg_index_i <= REG_STREAM_MIN;
    cfg_data_i <= smin;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(REG_WINDOW_PER_DGRAM, wpd);
    sb.set_reg(REG_WINDOW_CAP, cap);
    sb.set_reg(REG_STRAY_LIMIT, stray);
    sb.set_reg(REG_STREAM_MIN, smin);
  endtask

  function automatic logic [8:0] pick_count();
    int r;
    r = $urandom_range(0, 199);
    if (r < 130) return 9'($urandom_range(1, 8));
    if (r < 175) return 9'($urandom_range(9, 40));
    if (r < 190) return 9'($urandom_range(41, 100));
    if (r < 196) return 9'($urandom_range(101, 256));
    if (r < 198) return 9'($urandom_range(257, 511));
    return 9'd0;
  endfunction

  // Mostly in-order datagram streams with skips, strays, sender restarts and noise.
  task automatic random_traffic(int n, bit with_hold);
    int          r;
    logic [15:0] s;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_req_count++;
      r = $urandom_range(0, 99);
      if (sb.active) begin
        if (r < 68) begin
          s = gen_next;
          gen_next++;
          offer(OP_DATAGRAM, 5'($urandom), 9'($urandom), s);
        end else if (r < 78) begin
          gen_next += 16'($urandom_range(1, 4));
          s = gen_next;
          gen_next++;
          offer(OP_DATAGRAM, 5'($urandom), 9'($urandom), s);
        end else if (r < 87) begin
          s = gen_next - 16'($urandom_range(1, 6));
          offer(OP_DATAGRAM, 5'($urandom), 9'($urandom), s);
        end else if (r < 91) begin
          // sender counter restarts a little behind
          gen_next -= 16'($urandom_range(3, 80));
          s = gen_next;
          gen_next++;
          offer(OP_DATAGRAM, 5'($urandom), 9'($urandom), s);
        end else if (r < 93) begin
          gen_next = 16'($urandom);
          s = gen_next;
          gen_next++;
          offer(OP_DATAGRAM, 5'($urandom), 9'($urandom), s);
        end else if (r < 97) begin
          offer(OP_TIMEOUT, 5'($urandom), 9'($urandom), 16'($urandom));
          if ($urandom_range(0, 1) == 1) gen_next = sb.expect_seq;
        end else if (r < 99) begin
          offer(OP_BEGIN, 5'($urandom), pick_count(), 16'($urandom));
        end else begin
          offer(OP_RESERVED, 5'($urandom), 9'($urandom), 16'($urandom));
        end
      end else begin
        if (r < 88) offer(OP_BEGIN, 5'($urandom), pick_count(), 16'($urandom));
        else if (r < 93) offer(OP_DATAGRAM, 5'($urandom), 9'($urandom), 16'($urandom));
        else if (r < 96) offer(OP_TIMEOUT, 5'($urandom), 9'($urandom), 16'($urandom));
        else offer(OP_RESERVED, 5'($urandom), 9'($urandom), 16'($urandom));
      end
    end
  endtask

  // Result side: check each beat, stall on shifting patterns or a long hold-off.
  initial begin
    result_t got;
    int      mode;
    int      mode_left;
    int      hold_left;
    int      holds_taken;
    bit      stall;
    mode = 0;
    mode_left = 100;
    hold_left = 0;
    holds_taken = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.kind = kind_e'(kind_o);
        got.slot = slot_out_o;
        got.index = index_o;
        got.carry = from_carry_o;
        got.hstart = hole_start_o;
        got.hcount = hole_count_o;
        got.rkind = restart_e'(restart_kind_o);
        got.recv = received_count_o;
        got.tmo = timed_out_o;
        got.tail = tail_lost_o;
        got.last = last_o;
        sb.check_result(got);
      end
      if (hold_left == 0 && holds_taken != hold_req_count) begin
        holds_taken++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: stall = 1'b0;
          1: stall = $urandom_range(0, 99) < 25;
          2: stall = $urandom_range(0, 99) < 75;
          default: stall = (mode_left % 5) < 2;
        endcase
      end
      out_stall_i <= stall;
    end
  end

  initial begin
    sb = new();
    burst_left = 0;
    hold_req_count = 0;
    gen_next = 16'($urandom);
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_WINDOW_PER_DGRAM;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= OP_BEGIN;
    slot_i <= '0;
    count_i <= '0;
    seq_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle and malformed events are refused
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0000);
    offer(OP_TIMEOUT, 5'd0, 9'd0, 16'h0000);
    offer(OP_RESERVED, 5'd31, 9'd511, 16'hFFFF);
    offer(OP_BEGIN, 5'd0, 9'd0, 16'h0000);
    // oversized count saturates; a second begin is refused; timeout with nothing placed
    offer(OP_BEGIN, 5'd31, 9'd511, 16'h0000);
    offer(OP_BEGIN, 5'd5, 9'd4, 16'h0000);
    offer(OP_TIMEOUT, 5'd0, 9'd0, 16'h0000);
    // wrap across zero with a hole, a stray, then fill
    offer(OP_BEGIN, 5'd3, 9'd4, 16'h0000);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'hFFFF);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0001);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'hFFFE);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0002);
    // beyond the end: hold, then place the held datagram at the next begin
    offer(OP_BEGIN, 5'd7, 9'd3, 16'h0000);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0007);
    offer(OP_BEGIN, 5'd8, 9'd2, 16'h0000);
    // window jump restart
    offer(OP_BEGIN, 5'd9, 9'd1, 16'h0000);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0100);
    // held datagram held again at begin
    offer(OP_BEGIN, 5'd10, 9'd2, 16'h0000);
    offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0110);
    offer(OP_BEGIN, 5'd11, 9'd1, 16'h0000);
    offer(OP_BEGIN, 5'd12, 9'd20, 16'h0000);
    // stale run ending behind the write position
    for (int i = 0; i < 8; i++) offer(OP_DATAGRAM, 5'd0, 9'd0, 16'h0108 - 16'(i));
    offer(OP_TIMEOUT, 5'd0, 9'd0, 16'h0000);

    random_traffic(390, 1'b0);
    settle();
    program_regs(15'd1, 15'd1, 15'd1, 15'd1);
    random_traffic(390, 1'b1);
    settle();
    program_regs(15'd64, 15'd32767, 15'd15, 15'd256);
    random_traffic(390, 1'b0);
    settle();
    program_regs(15'($urandom_range(1, 64)), 15'($urandom_range(16, 2000)),
                 15'($urandom_range(2, 10)), 15'($urandom_range(1, 64)));
    random_traffic(390, 1'b1);
    settle();
    program_regs(15'd32, 15'd16384, 15'd8, 15'd32);
    random_traffic(390, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("datagram_sequence_placer_tb: PASS");
    end else begin
      $display("datagram_sequence_placer_tb: FAIL");
    end
    $finish;
  end

endmodule
